// File: hdl/cjpr_pkg.sv
// ----------------------------------------------------------------------------
// cjpr_pkg
// shared types and constants of the cookie jar publish/remove block
// ----------------------------------------------------------------------------
package cjpr_pkg;

  localparam int JAR_PAIRS_DEFAULT = 16;
  localparam int WORD_W            = 32;
  localparam int PAIR_W            = 2 * WORD_W;

  // configuration register indexes
  localparam logic REG_COOKIE_ID   = 1'b0;
  localparam logic REG_JAR_PRESENT = 1'b1;

  // input command codes
  localparam logic CMD_PUBLISH = 1'b0;
  localparam logic CMD_REMOVE  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_CHECK,
    ST_APPEND,
    ST_SHIFT_READ,
    ST_SHIFT_CHECK,
    ST_FINISH
  } state_t;

  typedef enum logic [2:0] {
    WR_NONE,
    WR_PAIR,       // {cookie_id, value} at the index
    WR_TERM_NEXT,  // terminator with count minus one at index plus one
    WR_SHIFT,      // pair read from index plus one, moved down to the index
    WR_LAST        // fresh terminator with count one at the index
  } wr_op_t;

  typedef struct packed {
    logic   load_in;
    logic   idx_clear;
    logic   idx_inc;
    logic   rd_en;
    logic   rd_next;
    wr_op_t wr_op;
    logic   set_res;
    logic   res_ok;
    logic   res_rep;
    logic   load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic op_remove;
    logic jar_ok;
    logic id_match;
    logic id_zero;
    logic free_ge2;
    logic at_last;
    logic out_busy;
  } dp_status_t;

endpackage

// File: hdl/cjpr_ram.sv
// ----------------------------------------------------------------------------
// cjpr_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module cjpr_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hdl/cjpr_ctrl.sv
// ----------------------------------------------------------------------------
// cjpr_ctrl
// sequencer for search, append and shift-down walks over the pair table
// ----------------------------------------------------------------------------
module cjpr_ctrl import cjpr_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_status_t sts,
  output dp_cmd_t    dcmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    dcmd       = '0;
    dcmd.wr_op = WR_NONE;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          dcmd.load_in   = 1'b1;
          dcmd.idx_clear = 1'b1;
          dcmd.set_res   = 1'b1;
          state_next     = sts.jar_ok ? ST_READ : ST_FINISH;
        end
      end
      ST_READ: begin
        dcmd.rd_en = 1'b1;
        state_next = ST_CHECK;
      end
      ST_CHECK: begin
        if (sts.id_match) begin
          if (sts.op_remove) begin
            state_next = ST_SHIFT_READ;
          end else begin
            dcmd.wr_op   = WR_PAIR;
            dcmd.set_res = 1'b1;
            dcmd.res_ok  = 1'b1;
            dcmd.res_rep = 1'b1;
            state_next   = ST_FINISH;
          end
        end else if (sts.id_zero) begin
          // terminator reached: append only on publish with room left
          if (!sts.op_remove && sts.free_ge2 && !sts.at_last) begin
            dcmd.wr_op = WR_TERM_NEXT;
            state_next = ST_APPEND;
          end else begin
            state_next = ST_FINISH;
          end
        end else if (sts.at_last) begin
          state_next = ST_FINISH;
        end else begin
          dcmd.idx_inc = 1'b1;
          state_next   = ST_READ;
        end
      end
      ST_APPEND: begin
        dcmd.wr_op   = WR_PAIR;
        dcmd.set_res = 1'b1;
        dcmd.res_ok  = 1'b1;
        state_next   = ST_FINISH;
      end
      ST_SHIFT_READ: begin
        if (sts.at_last) begin
          // no terminator after the match: last pair becomes one
          dcmd.wr_op   = WR_LAST;
          dcmd.set_res = 1'b1;
          dcmd.res_ok  = 1'b1;
          state_next   = ST_FINISH;
        end else begin
          dcmd.rd_en   = 1'b1;
          dcmd.rd_next = 1'b1;
          state_next   = ST_SHIFT_CHECK;
        end
      end
      ST_SHIFT_CHECK: begin
        dcmd.wr_op = WR_SHIFT;
        if (sts.id_zero) begin
          dcmd.set_res = 1'b1;
          dcmd.res_ok  = 1'b1;
          state_next   = ST_FINISH;
        end else begin
          dcmd.idx_inc = 1'b1;
          state_next   = ST_SHIFT_READ;
        end
      end
      ST_FINISH: begin
        if (!sts.out_busy) begin
          dcmd.load_out = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE || state == ST_FINISH) |-> dcmd.wr_op == WR_NONE)
    else $error("table write outside a walk");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    dcmd.load_out |-> !sts.out_busy)
    else $error("result loaded over an untaken result");

  a_leave_idle: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> state != ST_IDLE)
    else $error("request accepted without starting");
`endif

endmodule

// File: hdl/cjpr_dp.sv
// ----------------------------------------------------------------------------
// cjpr_dp
// datapath: config registers, pair table, walk index and result register
// ----------------------------------------------------------------------------
module cjpr_dp import cjpr_pkg::*; #(
  parameter int JAR_PAIRS = JAR_PAIRS_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [WORD_W-1:0] cfg_data,
  input  logic              cmd,
  input  logic [WORD_W-1:0] cookie_value,
  input  dp_cmd_t           dcmd,
  output dp_status_t        sts,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              ok,
  output logic              repointed
);

  localparam int IDX_W = $clog2(JAR_PAIRS);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(JAR_PAIRS - 1);

  logic [WORD_W-1:0] cookie_id;
  logic              jar_present;
  logic              op_remove;
  logic [WORD_W-1:0] value_hold;
  logic [IDX_W-1:0]  idx;
  logic [IDX_W-1:0]  rd_addr;
  logic              slot0_fresh;
  logic              res_ok;
  logic              res_rep;

  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  logic [PAIR_W-1:0] ram_wdata;
  logic [IDX_W-1:0]  ram_raddr;
  logic [PAIR_W-1:0] ram_rdata;
  logic [WORD_W-1:0] rd_id;
  logic [WORD_W-1:0] rd_val;

  always_ff @(posedge clk) begin
    if (rst) begin
      cookie_id   <= WORD_W'(1);
      jar_present <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_COOKIE_ID:   cookie_id   <= cfg_data;
        REG_JAR_PRESENT: jar_present <= cfg_data[0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (dcmd.load_in) begin
      op_remove  <= cmd;
      value_hold <= cookie_value;
    end
    if (dcmd.idx_clear) begin
      idx <= '0;
    end else if (dcmd.idx_inc) begin
      idx <= idx + 1'b1;
    end
    if (dcmd.rd_en) begin
      rd_addr <= ram_raddr;
    end
  end

  assign ram_raddr = dcmd.rd_next ? idx + 1'b1 : idx;

  // pair 0 reads as an empty jar until it is first written
  always_ff @(posedge clk) begin
    if (rst) begin
      slot0_fresh <= 1'b1;
    end else if (ram_we && ram_waddr == '0) begin
      slot0_fresh <= 1'b0;
    end
  end

  always_comb begin
    if (slot0_fresh && rd_addr == '0) begin
      rd_id  = '0;
      rd_val = WORD_W'(JAR_PAIRS);
    end else begin
      rd_id  = ram_rdata[PAIR_W-1:WORD_W];
      rd_val = ram_rdata[WORD_W-1:0];
    end
  end

  always_comb begin
    ram_we    = 1'b1;
    ram_waddr = idx;
    ram_wdata = '0;
    case (dcmd.wr_op)
      WR_PAIR: begin
        ram_wdata = {cookie_id, value_hold};
      end
      WR_TERM_NEXT: begin
        ram_waddr = idx + 1'b1;
        ram_wdata = {{WORD_W{1'b0}}, rd_val - 1'b1};
      end
      WR_SHIFT: begin
        ram_wdata = {rd_id, (rd_id == '0) ? rd_val + 1'b1 : rd_val};
      end
      WR_LAST: begin
        ram_wdata = {{WORD_W{1'b0}}, WORD_W'(1)};
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  cjpr_ram #(
    .WIDTH(PAIR_W),
    .DEPTH(JAR_PAIRS)
  ) u_pairs (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (dcmd.rd_en),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (dcmd.set_res) begin
      res_ok  <= dcmd.res_ok;
      res_rep <= dcmd.res_rep;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (dcmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (dcmd.load_out) begin
      ok        <= res_ok;
      repointed <= res_rep;
    end
  end

  always_comb begin
    sts.op_remove = (op_remove == CMD_REMOVE);
    sts.jar_ok    = jar_present && (cookie_id != '0);
    sts.id_match  = (rd_id == cookie_id);
    sts.id_zero   = (rd_id == '0);
    sts.free_ge2  = |rd_val[WORD_W-1:1];
    sts.at_last   = (idx == LAST_IDX);
    sts.out_busy  = out_valid && !out_ready;
  end

`ifndef SYNTHESIS
  a_rep_implies_ok: assert property (@(posedge clk) disable iff (rst)
    (out_valid && repointed) |-> ok)
    else $error("repointed result without success");
`endif

endmodule

// File: hdl/cookie_jar_publish_remove.sv
// ----------------------------------------------------------------------------
// cookie_jar_publish_remove
// publishes, repoints and removes one cookie in an id/value pair table
// ----------------------------------------------------------------------------
// requests enter on in_valid/in_ready with cmd (publish or remove) and
// cookie_value; each request gives exactly one result on out_valid/out_ready
// carrying ok and repointed. config must be written through cfg_we/cfg_index/
// cfg_data only while no request is in flight; the block does not enforce it.
// one request is worked at a time. the walk reads the pair ram once per pair
// in a read state and a check state; an append adds a write state, and a
// remove adds a read and a check state for each pair shifted down. the pace
// of the walk is set by the single read port of the pair ram.
// after reset the table holds only a terminator with JAR_PAIRS free pairs,
// cookie_id is 1 and the jar is present; no clearing pass is needed.
// the result sits in an output register: a new request is taken while it
// waits, and that request's walk holds at its end until the result is taken.
// ----------------------------------------------------------------------------
module cookie_jar_publish_remove import cjpr_pkg::*; #(
  parameter int JAR_PAIRS = JAR_PAIRS_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [WORD_W-1:0] cfg_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              cmd,
  input  logic [WORD_W-1:0] cookie_value,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              ok,
  output logic              repointed
);

  dp_cmd_t    dcmd;
  dp_status_t sts;

  cjpr_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .sts     (sts),
    .dcmd    (dcmd)
  );

  cjpr_dp #(
    .JAR_PAIRS(JAR_PAIRS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .cmd         (cmd),
    .cookie_value(cookie_value),
    .dcmd        (dcmd),
    .sts         (sts),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .ok          (ok),
    .repointed   (repointed)
  );

endmodule
